// File: rtl/core/i2cmts_pkg.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Shared types, codes and constants of the transfer sequencer.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

   // Fixed field widths
   localparam int COUNT_W = 6;
   localparam int TICK_W  = 9;

   // Timeout register limits and reset value
   localparam logic [TICK_W-1:0] TIMEOUT_MIN   = 9'd10;
   localparam logic [TICK_W-1:0] TIMEOUT_MAX   = 9'd500;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 9'd100;
   localparam logic [TICK_W-1:0] TICK_MAX      = 9'd511;

   // Transaction kinds
   localparam logic [2:0] KIND_START_WRITE = 3'd0;
   localparam logic [2:0] KIND_START_READ  = 3'd1;
   localparam logic [2:0] KIND_LOAD        = 3'd2;
   localparam logic [2:0] KIND_EVENT       = 3'd3;
   localparam logic [2:0] KIND_TICK        = 3'd4;
   localparam logic [2:0] KIND_RETIRE      = 3'd5;

   // Transfer phase, one-hot
   typedef enum logic [5:0] {
      PH_IDLE     = 6'b000001,
      PH_STARTED  = 6'b000010,
      PH_ADDRESS  = 6'b000100,
      PH_EXCHANGE = 6'b001000,
      PH_ENDED_OK = 6'b010000,
      PH_ERROR    = 6'b100000
   } phase_type;

   // One request transaction
   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         target_address;
      logic [COUNT_W-1:0] length;
      logic [4:0]         byte_index;
      logic [7:0]         write_byte;
      logic               flag_sb;
      logic               flag_addr;
      logic               flag_btf;
      logic               flag_rxne;
      logic [7:0]         received_byte;
   } req_type;

   // One response transaction
   typedef struct packed {
      logic               accepted;
      logic               issue_start;
      logic               send_valid;
      logic [7:0]         send_byte;
      logic               issue_stop;
      logic               clear_ack;
      logic               done_res;
      logic               error;
      logic [COUNT_W-1:0] handled_count;
      logic               read_valid;
      logic [7:0]         read_byte;
      logic [4:0]         read_index;
   } rsp_type;

   // Transfer state
   typedef struct packed {
      phase_type          phase;
      logic               is_read;
      logic [7:0]         saved_address;
      logic [COUNT_W-1:0] requested_count;
      logic [COUNT_W-1:0] done_count;
      logic               ready_flag;
      logic [TICK_W-1:0]  elapsed_ticks;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:           PH_IDLE,
      is_read:         1'b0,
      saved_address:   8'd0,
      requested_count: 6'd0,
      done_count:      6'd0,
      ready_flag:      1'b0,
      elapsed_ticks:   9'd0
   };

   // Buffer write request
   typedef struct packed {
      logic               en;
      logic [COUNT_W-1:0] index;
      logic [7:0]         data;
   } buf_wr_type;

endpackage

// File: rtl/core/i2cmts_buffer.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer data buffer
// Byte buffer with one write port and two registered read ports that
// prefetch the slot at the byte count and the slot after it.
// ----------------------------------------------------------------------------
module i2cmts_buffer #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic                        clock,
   input  i2cmts_pkg::buf_wr_type      wr,
   input  logic [i2cmts_pkg::COUNT_W-1:0] rd_index,
   output logic [7:0]                  cur_data,
   output logic [7:0]                  nxt_data
);
   import i2cmts_pkg::*;

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int IW = (AW > COUNT_W) ? AW : COUNT_W;

   logic [7:0]    mem [BUFFER_DEPTH];
   logic [IW-1:0] rd_ext;
   logic [IW-1:0] rd_ext_next;
   logic [IW-1:0] wr_ext;
   logic [AW-1:0] addr_cur;
   logic [AW-1:0] addr_nxt;
   logic [AW-1:0] addr_wr;
   logic [7:0]    cur_data_ff;
   logic [7:0]    nxt_data_ff;

   // Address formation
   assign rd_ext      = IW'(rd_index);
   assign rd_ext_next = rd_ext + IW'(1);
   assign wr_ext      = IW'(wr.index);
   assign addr_cur    = rd_ext[AW-1:0];
   assign addr_nxt    = rd_ext_next[AW-1:0];
   assign addr_wr     = wr_ext[AW-1:0];

   // Storage write
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[addr_wr] <= wr.data;
      end
   end

   // Registered reads, forwarding a write to the same slot
   always_ff @(posedge clock) begin
      if (wr.en && (addr_wr == addr_cur)) begin
         cur_data_ff <= wr.data;
      end else begin
         cur_data_ff <= mem[addr_cur];
      end
      if (wr.en && (addr_wr == addr_nxt)) begin
         nxt_data_ff <= wr.data;
      end else begin
         nxt_data_ff <= mem[addr_nxt];
      end
   end

   assign cur_data = cur_data_ff;
   assign nxt_data = nxt_data_ff;

endmodule

// File: rtl/core/i2cmts_step.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer step logic
// Works out the response and the next transfer state for one transaction.
// ----------------------------------------------------------------------------
module i2cmts_step #(
   parameter int BUFFER_DEPTH = 32
) (
   input  i2cmts_pkg::state_type        st,
   input  i2cmts_pkg::req_type          req,
   input  logic [i2cmts_pkg::TICK_W-1:0] timeout,
   input  logic [7:0]                   buf_cur,
   input  logic [7:0]                   buf_nxt,
   output i2cmts_pkg::state_type        nxt,
   output i2cmts_pkg::rsp_type          rsp,
   output i2cmts_pkg::buf_wr_type       wr
);
   import i2cmts_pkg::*;

   logic               active;
   logic               handled;
   logic               rx_taken;
   logic [COUNT_W-1:0] rx_count;
   logic [TICK_W-1:0]  tick_count;

   assign active     = st.phase inside {PH_STARTED, PH_ADDRESS, PH_EXCHANGE};
   assign rx_count   = st.done_count + 6'd1;
   assign tick_count = (st.elapsed_ticks < TICK_MAX) ? st.elapsed_ticks + 9'd1
                                                     : st.elapsed_ticks;

   // Transaction decode and state update
   always_comb begin
      nxt      = st;
      rsp      = '0;
      wr       = '0;
      handled  = 1'b0;
      rx_taken = 1'b0;
      case (req.kind)
         KIND_START_WRITE, KIND_START_READ: begin
            if ((st.phase == PH_IDLE) && (int'(req.length) <= BUFFER_DEPTH)) begin
               nxt.is_read         = (req.kind == KIND_START_READ);
               nxt.saved_address   = req.target_address;
               nxt.requested_count = req.length;
               nxt.done_count      = '0;
               nxt.ready_flag      = 1'b0;
               nxt.elapsed_ticks   = '0;
               nxt.phase           = PH_STARTED;
               rsp.accepted        = 1'b1;
               rsp.issue_start     = 1'b1;
            end
         end
         KIND_LOAD: begin
            if (int'(req.byte_index) < BUFFER_DEPTH) begin
               wr.en    = 1'b1;
               wr.index = {1'b0, req.byte_index};
               wr.data  = req.write_byte;
            end
         end
         KIND_EVENT: begin
            if (active) begin
               // Byte transfer finished: next write byte or stop
               if (req.flag_btf) begin
                  handled = 1'b1;
                  if (!st.is_read) begin
                     if (st.done_count < st.requested_count) begin
                        rsp.send_valid = 1'b1;
                        rsp.send_byte  = buf_cur;
                        nxt.done_count = rx_count;
                     end else begin
                        rsp.issue_stop = 1'b1;
                        nxt.phase      = PH_ENDED_OK;
                        nxt.ready_flag = 1'b1;
                        rsp.done_res   = 1'b1;
                     end
                  end
               end
               // Received byte: store it and close the read near its end
               if (!handled && req.flag_rxne &&
                   (st.done_count < st.requested_count)) begin
                  rx_taken       = 1'b1;
                  wr.en          = (int'(st.done_count) < BUFFER_DEPTH);
                  wr.index       = st.done_count;
                  wr.data        = req.received_byte;
                  rsp.read_valid = 1'b1;
                  rsp.read_byte  = req.received_byte;
                  rsp.read_index = st.done_count[4:0];
                  nxt.done_count = rx_count;
                  if ((st.requested_count != '0) &&
                      (rx_count == st.requested_count - 6'd1)) begin
                     rsp.clear_ack = 1'b1;
                     rsp.issue_stop = 1'b1;
                     handled       = 1'b1;
                  end else if (rx_count == st.requested_count) begin
                     nxt.phase      = PH_ENDED_OK;
                     nxt.ready_flag = 1'b1;
                     rsp.done_res   = 1'b1;
                     handled        = 1'b1;
                  end
               end
               // Start condition sent: transmit the address byte
               if (!handled && req.flag_sb) begin
                  handled        = 1'b1;
                  nxt.phase      = PH_ADDRESS;
                  rsp.send_valid = 1'b1;
                  rsp.send_byte  = st.saved_address;
               end
               // Address acknowledged: begin the data exchange
               if (!handled && req.flag_addr) begin
                  if ((st.requested_count == 6'd1) && st.is_read) begin
                     rsp.clear_ack  = 1'b1;
                     rsp.issue_stop = 1'b1;
                  end
                  if (!st.is_read && (nxt.done_count < st.requested_count)) begin
                     rsp.send_valid = 1'b1;
                     rsp.send_byte  = rx_taken ? buf_nxt : buf_cur;
                     nxt.done_count = nxt.done_count + 6'd1;
                  end
                  nxt.phase = PH_EXCHANGE;
               end
            end
         end
         KIND_TICK: begin
            if (active) begin
               nxt.elapsed_ticks = tick_count;
               if (tick_count >= timeout) begin
                  nxt.phase      = PH_ERROR;
                  nxt.ready_flag = 1'b1;
                  rsp.done_res   = 1'b1;
                  rsp.error      = 1'b1;
               end
            end
         end
         KIND_RETIRE: begin
            if (st.ready_flag) begin
               nxt.ready_flag = 1'b0;
               rsp.done_res   = 1'b1;
               rsp.error      = (st.phase != PH_ENDED_OK);
               nxt.phase      = PH_IDLE;
            end
         end
         default: begin
         end
      endcase
      rsp.handled_count = nxt.done_count;
   end

endmodule

// File: rtl/core/i2c_master_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Sequences one I2C master write or read, turning peripheral events and
// millisecond ticks into bus commands, received bytes and completion reports.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Carries
//   req_     in         req_valid / req_ready  one request transaction
//   rsp_     out        rsp_valid / rsp_ready  one response per request
//   csr_     in         csr_valid / csr_ready  timeout_ms write (always ready)
//
// A request accepted into the input register is worked on by the step logic while
// it sits there, and its response is captured in the response register, from
// which it is offered on the response channel.
// A new request can be taken every cycle; the response register is the only
// point of backpressure, and a stalled response holds the input register.
// Synchronous reset returns the transfer to idle and the timeout to 100 ms.
// The buffer itself is not cleared; its prefetched slots follow the count.
//
module i2c_master_transfer_sequencer #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   // Request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_target_address,
   input  logic [5:0] req_length,
   input  logic [4:0] req_byte_index,
   input  logic [7:0] req_write_byte,
   input  logic       req_flag_sb,
   input  logic       req_flag_addr,
   input  logic       req_flag_btf,
   input  logic       req_flag_rxne,
   input  logic [7:0] req_received_byte,
   // Response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_accepted,
   output logic       rsp_issue_start,
   output logic       rsp_send_valid,
   output logic [7:0] rsp_send_byte,
   output logic       rsp_issue_stop,
   output logic       rsp_clear_ack,
   output logic       rsp_done_res,
   output logic       rsp_error,
   output logic [5:0] rsp_handled_count,
   output logic       rsp_read_valid,
   output logic [7:0] rsp_read_byte,
   output logic [4:0] rsp_read_index,
   // Configuration channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [8:0] csr_wdata
);
   import i2cmts_pkg::*;

   logic              in_valid_ff;
   req_type           req_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   state_type         state_ff;
   state_type         state_in;
   state_type         step_state;
   rsp_type           step_rsp;
   buf_wr_type        step_wr;
   buf_wr_type        buf_wr;
   logic [TICK_W-1:0] timeout_ff;
   logic [7:0]        buf_cur;
   logic [7:0]        buf_nxt;
   logic              advance;
   logic              process;

   // Pipeline control
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign process   = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= '{kind:           req_kind,
                     target_address: req_target_address,
                     length:         req_length,
                     byte_index:     req_byte_index,
                     write_byte:     req_write_byte,
                     flag_sb:        req_flag_sb,
                     flag_addr:      req_flag_addr,
                     flag_btf:       req_flag_btf,
                     flag_rxne:      req_flag_rxne,
                     received_byte:  req_received_byte};
      end
   end

   // Timeout register; values outside the legal range are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid && (csr_wdata >= TIMEOUT_MIN) &&
                   (csr_wdata <= TIMEOUT_MAX)) begin
         timeout_ff <= csr_wdata;
      end
   end

   // Step logic for the transaction in the input register
   i2cmts_step #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_step (
      .st      (state_ff),
      .req     (req_ff),
      .timeout (timeout_ff),
      .buf_cur (buf_cur),
      .buf_nxt (buf_nxt),
      .nxt     (step_state),
      .rsp     (step_rsp),
      .wr      (step_wr)
   );

   // State update only when a transaction is processed
   always_comb begin
      state_in = state_ff;
      buf_wr   = '0;
      if (process) begin
         state_in = step_state;
         buf_wr   = step_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   // Data buffer, prefetching at the next byte count
   i2cmts_buffer #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_buffer (
      .clock    (clock),
      .wr       (buf_wr),
      .rd_index (state_in.done_count),
      .cur_data (buf_cur),
      .nxt_data (buf_nxt)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_ff.accepted;
   assign rsp_issue_start   = rsp_ff.issue_start;
   assign rsp_send_valid    = rsp_ff.send_valid;
   assign rsp_send_byte     = rsp_ff.send_byte;
   assign rsp_issue_stop    = rsp_ff.issue_stop;
   assign rsp_clear_ack     = rsp_ff.clear_ack;
   assign rsp_done_res      = rsp_ff.done_res;
   assign rsp_error         = rsp_ff.error;
   assign rsp_handled_count = rsp_ff.handled_count;
   assign rsp_read_valid    = rsp_ff.read_valid;
   assign rsp_read_byte     = rsp_ff.read_byte;
   assign rsp_read_index    = rsp_ff.read_index;

   // Assertions
   a_timeout_range : assert property (@(posedge clock) disable iff (reset)
      (timeout_ff >= TIMEOUT_MIN) && (timeout_ff <= TIMEOUT_MAX))
      else $error("Timeout register left its legal range.");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff.done_count <= state_ff.requested_count)
      else $error("Byte count ran past the requested length.");

   a_ready_phase : assert property (@(posedge clock) disable iff (reset)
      state_ff.ready_flag |->
         ((state_ff.phase == PH_ENDED_OK) || (state_ff.phase == PH_ERROR)))
      else $error("Transfer marked ready to retire outside an end phase.");

   a_process_rsp : assert property (@(posedge clock) disable iff (reset)
      process |=> rsp_valid_ff)
      else $error("Processed transaction produced no response.");

endmodule
